>>> hdl/utf8tc_pkg.sv
// utf8tc_pkg: shared types, constants and helpers for the UTF-8 text cell decoder.
// Depends on nothing; used by the channel interfaces and the decoder top level.
`timescale 1ns / 1ps

package utf8tc_pkg;

    // One byte of a string, with the start position carried by the first byte
    typedef struct packed {
        logic       first_byte;
        logic [3:0] start_column;
        logic [1:0] start_row;
        logic [7:0] text_byte;
    } in_item_t;

    // One decoded character written to a text cell
    typedef struct packed {
        logic [4:0]  cell_index;
        logic [15:0] glyph_code;
    } out_item_t;

    localparam int ACC_W = 32;
    localparam int LEN_W = 3;

    localparam logic [ACC_W-1:0] GLYPH_MIN = 32'h0000_0020;
    localparam logic [ACC_W-1:0] GLYPH_MAX = 32'h0000_FFFF;

    // Sum of the lead-byte marker bits folded in by the shift-add, per trailing count
    function automatic logic [ACC_W-1:0] seq_offset(input logic [LEN_W-1:0] len);
        logic [ACC_W-1:0] off;
        begin
            case (len)
                3'd1:    off = 32'h0000_3080;
                3'd2:    off = 32'h000E_2080;
                3'd3:    off = 32'h03C8_2080;
                3'd4:    off = 32'hFA08_2080;
                3'd5:    off = 32'h8208_2080;
                default: off = 32'h0000_0000;
            endcase
            return off;
        end
    endfunction

    // Trailing byte count selected by a lead byte
    function automatic logic [LEN_W-1:0] trailing_count(input logic [7:0] b);
        logic [LEN_W-1:0] n;
        begin
            if (b < 8'hC0)      n = 3'd0;
            else if (b < 8'hE0) n = 3'd1;
            else if (b < 8'hF0) n = 3'd2;
            else if (b < 8'hF8) n = 3'd3;
            else if (b < 8'hFC) n = 3'd4;
            else                n = 3'd5;
            return n;
        end
    endfunction

endpackage

>>> hdl/utf8tc_in_if.sv
// utf8tc_in_if: valid/ready channel carrying string bytes into the decoder.
// Depends on utf8tc_pkg for the payload type.
`timescale 1ns / 1ps

interface utf8tc_in_if;
    logic                valid;
    logic                ready;
    utf8tc_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/utf8tc_out_if.sv
// utf8tc_out_if: valid/ready channel carrying decoded cell writes out of the decoder.
// Depends on utf8tc_pkg for the payload type.
`timescale 1ns / 1ps

interface utf8tc_out_if;
    logic                 valid;
    logic                 ready;
    utf8tc_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/utf8_text_cell_decoder.sv
// utf8_text_cell_decoder: turns a UTF-8 byte stream into (cell index, glyph code) writes.
// Depends on utf8tc_pkg, utf8tc_in_if and utf8tc_out_if.
//
// Usage:
//   text_in  : one string byte per transfer. first_byte=1 starts a new string at
//              (start_row, start_column); a start outside the ROWS x COLUMNS grid
//              drops the string until the next first_byte.
//   cell_out : one transfer per completed character: cell_index = row*COLUMNS+col
//              (low 5 bits), glyph_code = code point - 0x20, or 0 if out of range.
//   Bytes that finish no character (lead bytes, NUL terminator, ignored bytes)
//   produce no transfer.
// Throughput: one byte per cycle while cell_out is not held off. The per-byte work
//   is one 32-bit shift-add, one offset subtract and a range compare, done between
//   the input register and the result register.
// Path: the last byte of a character is captured in the input register and decoded,
//   and the result is loaded into the result register, which drives cell_out.valid.
// Stall: while cell_out is held off, the result register holds; the input
//   register still drains into it once it frees, so text_in stays ready as long
//   as either stage can move.
// Reset: rst_n clears both pipeline valids and returns the decoder to inactive.
`timescale 1ns / 1ps

module utf8_text_cell_decoder #(
    parameter int COLUMNS = 12,
    parameter int ROWS    = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    utf8tc_in_if.sink     text_in,
    utf8tc_out_if.source  cell_out
);

    // Cell position width: must hold ROWS*COLUMNS (one past the last cell)
    localparam int POS_RAW = $clog2(ROWS * COLUMNS + 1);
    localparam int POS_W   = (POS_RAW > 5) ? POS_RAW : 5;
    // Compare width for start checks: covers 4-bit column, COLUMNS-1 <= 31
    localparam int CHK_W   = 5;

    localparam logic [CHK_W-1:0] COL_MAX = CHK_W'(COLUMNS - 1);
    localparam logic [CHK_W-1:0] ROW_MAX = CHK_W'(ROWS - 1);
    localparam logic [POS_W-1:0] COLS_P  = POS_W'(COLUMNS);

    localparam int ACC_W = utf8tc_pkg::ACC_W;
    localparam int LEN_W = utf8tc_pkg::LEN_W;

    // ---------------- input register ----------------
    logic                 in_valid_reg;
    utf8tc_pkg::in_item_t in_data_reg;

    // ---------------- decoder state ----------------
    logic              active_reg,    active_next;
    logic [POS_W-1:0]  pos_reg,       pos_next;
    logic [POS_W-1:0]  line_end_reg,  line_end_next;
    logic [LEN_W-1:0]  left_reg,      left_next;
    logic [LEN_W-1:0]  seq_len_reg,   seq_len_next;
    logic [ACC_W-1:0]  acc_reg,       acc_next;

    // ---------------- result register ----------------
    logic                  out_valid_reg;
    utf8tc_pkg::out_item_t out_data_reg;

    logic                  emit;
    utf8tc_pkg::out_item_t result;

    // Decode stage moves when the result register is empty or being drained
    logic advance;
    assign advance       = !out_valid_reg || cell_out.ready;
    assign text_in.ready = !in_valid_reg || advance;

    assign cell_out.valid = out_valid_reg;
    assign cell_out.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text_in.ready)
        begin
            in_valid_reg <= text_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.ready && text_in.valid)
        begin
            in_data_reg <= text_in.data;
        end
    end

    // Single-pass decode of the registered byte
    always_comb
    begin
        logic [CHK_W-1:0] col_c;
        logic [CHK_W-1:0] row_c;
        logic [POS_W-1:0] row_base;
        logic [ACC_W-1:0] acc_v;
        logic [LEN_W-1:0] len_v;
        logic [ACC_W-1:0] code_point;
        logic [POS_W-1:0] pos_inc;
        logic             finish;
        logic             run;

        active_next   = active_reg;
        pos_next      = pos_reg;
        line_end_next = line_end_reg;
        left_next     = left_reg;
        seq_len_next  = seq_len_reg;
        acc_next      = acc_reg;
        emit          = 1'b0;
        finish        = 1'b0;
        run           = 1'b0;
        acc_v         = '0;
        len_v         = '0;
        pos_inc       = '0;

        col_c    = CHK_W'(in_data_reg.start_column);
        row_c    = CHK_W'(in_data_reg.start_row);
        row_base = POS_W'(POS_W'(in_data_reg.start_row) * COLS_P);

        if (in_valid_reg)
        begin
            run = active_reg;
            if (in_data_reg.first_byte)
            begin
                left_next    = '0;
                seq_len_next = '0;
                acc_next     = '0;
                if (row_c > ROW_MAX || col_c > COL_MAX)
                begin
                    active_next = 1'b0;
                    run         = 1'b0;
                end
                else
                begin
                    active_next   = 1'b1;
                    pos_next      = row_base + POS_W'(in_data_reg.start_column);
                    line_end_next = row_base + COLS_P;
                    run           = 1'b1;
                end
            end

            if (run)
            begin
                if (left_next == '0)
                begin
                    if (in_data_reg.text_byte == 8'h00)
                    begin
                        // Terminator at a character start ends the string
                        active_next = 1'b0;
                    end
                    else
                    begin
                        len_v        = utf8tc_pkg::trailing_count(in_data_reg.text_byte);
                        seq_len_next = len_v;
                        left_next    = len_v;
                        acc_next     = ACC_W'(in_data_reg.text_byte);
                        finish       = (len_v == '0);
                    end
                end
                else
                begin
                    acc_v     = acc_next;
                    acc_next  = {acc_v[ACC_W-7:0], 6'b0} + ACC_W'(in_data_reg.text_byte);
                    left_next = left_next - LEN_W'(1);
                    finish    = (left_next == '0);
                end
            end
        end

        code_point = acc_next - utf8tc_pkg::seq_offset(seq_len_next);
        result.cell_index = pos_next[4:0];
        if (code_point >= utf8tc_pkg::GLYPH_MIN && code_point <= utf8tc_pkg::GLYPH_MAX)
        begin
            result.glyph_code = 16'(code_point - utf8tc_pkg::GLYPH_MIN);
        end
        else
        begin
            result.glyph_code = 16'h0000;
        end

        if (finish)
        begin
            emit     = 1'b1;
            pos_inc  = pos_next + POS_W'(1);
            pos_next = pos_inc;
            // Row full: the string does not wrap
            if (pos_inc >= line_end_next)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            line_end_reg  <= '0;
            left_reg      <= '0;
            seq_len_reg   <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            line_end_reg  <= line_end_next;
            left_reg      <= left_next;
            seq_len_reg   <= seq_len_next;
            acc_reg       <= acc_next;
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg <= result;
        end
    end

endmodule
